// ===== rtl/mer_pkg.sv =====
package mer_pkg;

    // Default coordinate width of centers; pixels carry two more bits
    localparam int COORD_BITS_DEF = 12;

    // Radius and position widths
    localparam int R_W    = 11;
    localparam int RSQ_W  = 2 * R_W;
    localparam int POSX_W = 11;
    localparam int POSY_W = 12;

    // Shared multiplier operand and product widths
    localparam int MOP_W  = 24;
    localparam int PROD_W = 2 * MOP_W;

    // Slope terms and decision variable
    localparam int STEP_W = 48;
    localparam int DEC_W  = 52;

    // Command from the sequencer to the point emitter
    typedef struct packed {
        logic go;        // capture a new step
        logic no_shape;  // step while no ellipse is loaded: one dummy point
        logic done;      // these are the last points of the ellipse
    } emit_cmd_t;

endpackage

// ===== rtl/mer_mul.sv =====
module mer_mul import mer_pkg::*;
(
    input  logic              clk,
    input  logic [MOP_W-1:0]  a,
    input  logic [MOP_W-1:0]  b,
    output logic [PROD_W-1:0] p
);

    logic [PROD_W-1:0] p_reg;

    // Registered unsigned product
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// ===== rtl/mer_emit.sv =====
module mer_emit import mer_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  emit_cmd_t               cmd,
    input  logic [COORD_BITS-1:0]   center_x,
    input  logic [COORD_BITS-1:0]   center_y,
    input  logic [POSX_W-1:0]       pos_x,
    input  logic [POSY_W-1:0]       pos_y,
    output logic                    busy,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [COORD_BITS+1:0]   out_x,
    output logic [COORD_BITS+1:0]   out_y,
    output logic                    out_point_valid,
    output logic                    out_last,
    output logic                    out_done
);

    localparam int PIX_W = COORD_BITS + 2;

    logic             busy_reg;
    logic [1:0]       cnt_reg;
    logic             oval_reg;
    logic             single_reg;
    logic             done_reg;
    logic [PIX_W-1:0] xp_reg, xm_reg, yp_reg, ym_reg;
    logic [PIX_W-1:0] ox_reg, oy_reg;
    logic             opv_reg, olast_reg, odone_reg;

    logic [PIX_W-1:0] cx_w, cy_w, x_w, y_w;
    logic             load;
    logic             last_now;

    // Sums are taken modulo the pixel width
    assign cx_w = PIX_W'(center_x);
    assign cy_w = PIX_W'(center_y);
    assign x_w  = PIX_W'(pos_x);
    assign y_w  = PIX_W'(pos_y);

    // Output register takes the next point when empty or being drained
    assign load     = busy_reg && (!oval_reg || out_ready);
    assign last_now = single_reg || (cnt_reg == 2'd3);

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
            oval_reg <= 1'b0;
        end
        else
        begin
            if (cmd.go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (load)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (last_now)
                begin
                    busy_reg <= 1'b0;
                end
            end

            if (load)
            begin
                oval_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                oval_reg <= 1'b0;
            end
        end
    end

    // Point capture and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.go)
        begin
            single_reg <= cmd.no_shape;
            done_reg   <= cmd.done;
            if (cmd.no_shape)
            begin
                xp_reg <= '0;
                xm_reg <= '0;
                yp_reg <= '0;
                ym_reg <= '0;
            end
            else
            begin
                xp_reg <= cx_w + x_w;
                xm_reg <= cx_w - x_w;
                yp_reg <= cy_w + y_w;
                ym_reg <= cy_w - y_w;
            end
        end

        // Order: (+x,+y), (-x,+y), (+x,-y), (-x,-y)
        if (load)
        begin
            ox_reg    <= cnt_reg[0] ? xm_reg : xp_reg;
            oy_reg    <= cnt_reg[1] ? ym_reg : yp_reg;
            opv_reg   <= !single_reg;
            olast_reg <= last_now;
            odone_reg <= done_reg;
        end
    end

    assign busy            = busy_reg;
    assign out_valid       = oval_reg;
    assign out_x           = ox_reg;
    assign out_y           = oy_reg;
    assign out_point_valid = opv_reg;
    assign out_last        = olast_reg;
    assign out_done        = odone_reg;

endmodule

// ===== rtl/midpoint_ellipse_rasterizer_unit.sv =====
// Channel   Dir  tdata (low bit up)                          tuser / tlast
// s_axis    in   center_x, center_y, radius_x, radius_y      tuser[0] = op
// m_axis    out  pixel_x, pixel_y                            tuser = point_valid,
//                                                            ellipse_done; tlast =
//                                                            last_of_step
//
// Start item: accept, then three products on the shared multiplier; entering region
//   two at once adds five more products.
// Step item: accept, then the point emitter gives four points at one per cycle while
//   the output takes them; update, term and accumulate run alongside in the sequencer.
//   The switch to region two adds five more products. A step with no ellipse gives one point.
// rst_n clears all control state asynchronously; no ellipse is loaded after reset.
// Input is held off while the sequencer is busy or the emitter still has points
//   of the previous step; an output stall holds the emitter and its register.
module midpoint_ellipse_rasterizer_unit import mer_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    // center_x, center_y, radius_x, radius_y, zero fill
    input  logic [((2*COORD_BITS+2*R_W+7)/8)*8-1:0]      s_axis_tdata,
    // op
    input  logic [0:0]                                   s_axis_tuser,
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // pixel_x, pixel_y, zero fill
    output logic [((2*(COORD_BITS+2)+7)/8)*8-1:0]        m_axis_tdata,
    // point_valid, ellipse_done
    output logic [1:0]                                   m_axis_tuser,
    output logic                                         m_axis_tlast
);

    localparam int PIX_W      = COORD_BITS + 2;
    localparam int OUT_DATA_W = ((2*PIX_W+7)/8)*8;

    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_TERM = 5'b01000,
        ST_ACC  = 5'b10000
    } state_t;

    // Multiplier micro-ops
    typedef enum logic [2:0] {
        MOP_RX2  = 3'd0,  // rx*rx
        MOP_RY2  = 3'd1,  // ry*ry, D = 4ry2 + rx2
        MOP_DY0  = 3'd2,  // rx2*ry, dy = 2p, D -= 4p
        MOP_TX2  = 3'd3,  // (2x+1)^2
        MOP_D_TX = 3'd4,  // D = ry2*t
        MOP_TY2  = 3'd5,  // (y-1)^2
        MOP_D_TY = 3'd6,  // D += 4*rx2*t
        MOP_D_RR = 3'd7   // D -= 4*rx2*ry2
    } mop_t;

    state_t state_reg, state_next;
    mop_t   mop_reg, mop_next;
    logic   phase_reg, phase_next;
    logic   active_reg, active_next;
    logic   r2_reg, r2_next;
    logic   use_dx_reg, use_dx_next;
    logic   use_dy_reg, use_dy_next;

    logic [COORD_BITS-1:0]    cx_reg, cx_next, cy_reg, cy_next;
    logic [R_W-1:0]           rx_reg, rx_next, ry_reg, ry_next;
    logic [RSQ_W-1:0]         rx2_reg, rx2_next, ry2_reg, ry2_next;
    logic [MOP_W-1:0]         t_reg, t_next;
    logic [POSX_W-1:0]        x_reg, x_next;
    logic [POSY_W-1:0]        y_reg, y_next;
    logic signed [STEP_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [DEC_W-1:0]  dec_reg, dec_next, term_reg, term_next;

    logic                     in_acc;
    op_t                      in_op;
    logic [COORD_BITS-1:0]    in_cx, in_cy;
    logic [R_W-1:0]           in_rx, in_ry;

    logic [MOP_W-1:0]         mul_a, mul_b;
    logic [PROD_W-1:0]        mul_p;
    logic signed [DEC_W-1:0]  prod_d, prod_x4;
    logic signed [STEP_W-1:0] prod_x2;
    logic signed [STEP_W-1:0] ry2_step, rx2_step;
    logic signed [DEC_W-1:0]  rx2_d, ry2_d, dx_d, dy_d;
    logic [POSY_W-1:0]        ty_abs;
    logic [POSX_W:0]          tx;

    emit_cmd_t                emit_cmd;
    logic                     emit_busy;
    logic [PIX_W-1:0]         out_x, out_y;
    logic                     out_pv, out_done;

    // Input unpack
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign in_op  = op_t'(s_axis_tuser[0]);
    assign in_cx  = s_axis_tdata[COORD_BITS-1:0];
    assign in_cy  = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_rx  = s_axis_tdata[2*COORD_BITS+R_W-1:2*COORD_BITS];
    assign in_ry  = s_axis_tdata[2*COORD_BITS+2*R_W-1:2*COORD_BITS+R_W];

    assign s_axis_tready = (state_reg == ST_IDLE) && !emit_busy;

    // Extended operands
    assign prod_d   = $signed(DEC_W'(mul_p));
    assign prod_x4  = $signed(DEC_W'({mul_p, 2'b00}));
    assign prod_x2  = $signed(STEP_W'({mul_p, 1'b0}));
    assign ry2_step = $signed(STEP_W'({ry2_reg, 1'b0}));
    assign rx2_step = $signed(STEP_W'({rx2_reg, 1'b0}));
    assign rx2_d    = $signed(DEC_W'(rx2_reg));
    assign ry2_d    = $signed(DEC_W'(ry2_reg));
    assign dx_d     = DEC_W'(dx_reg);
    assign dy_d     = DEC_W'(dy_reg);
    assign tx       = {x_reg, 1'b1};
    assign ty_abs   = (y_reg == '0) ? POSY_W'(1) : y_reg - POSY_W'(1);

    // Operand select for the shared multiplier
    always_comb
    begin
        case (mop_reg)
            MOP_RX2:
            begin
                mul_a = MOP_W'(rx_reg);
                mul_b = MOP_W'(rx_reg);
            end
            MOP_RY2:
            begin
                mul_a = MOP_W'(ry_reg);
                mul_b = MOP_W'(ry_reg);
            end
            MOP_DY0:
            begin
                mul_a = MOP_W'(rx2_reg);
                mul_b = MOP_W'(ry_reg);
            end
            MOP_TX2:
            begin
                mul_a = MOP_W'(tx);
                mul_b = MOP_W'(tx);
            end
            MOP_D_TX:
            begin
                mul_a = MOP_W'(ry2_reg);
                mul_b = t_reg;
            end
            MOP_TY2:
            begin
                mul_a = MOP_W'(ty_abs);
                mul_b = MOP_W'(ty_abs);
            end
            MOP_D_TY:
            begin
                mul_a = MOP_W'(rx2_reg);
                mul_b = t_reg;
            end
            MOP_D_RR:
            begin
                mul_a = MOP_W'(rx2_reg);
                mul_b = MOP_W'(ry2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    mer_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        mop_next    = mop_reg;
        phase_next  = phase_reg;
        active_next = active_reg;
        r2_next     = r2_reg;
        use_dx_next = use_dx_reg;
        use_dy_next = use_dy_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        rx2_next    = rx2_reg;
        ry2_next    = ry2_reg;
        t_next      = t_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        dec_next    = dec_reg;
        term_next   = term_reg;
        emit_cmd    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_op == OP_START)
                    begin
                        cx_next     = in_cx;
                        cy_next     = in_cy;
                        rx_next     = in_rx;
                        ry_next     = in_ry;
                        x_next      = '0;
                        y_next      = POSY_W'(in_ry);
                        dx_next     = '0;
                        r2_next     = 1'b0;
                        active_next = 1'b1;
                        mop_next    = MOP_RX2;
                        phase_next  = 1'b0;
                        state_next  = ST_MUL;
                    end
                    else if (!active_reg)
                    begin
                        emit_cmd.go       = 1'b1;
                        emit_cmd.no_shape = 1'b1;
                    end
                    else
                    begin
                        emit_cmd.go   = 1'b1;
                        emit_cmd.done = r2_reg && (y_reg == '0);
                        state_next    = ST_UPD;
                    end
                end
            end

            // Position and slope terms
            ST_UPD:
            begin
                if (!r2_reg)
                begin
                    x_next      = x_reg + POSX_W'(1);
                    dx_next     = dx_reg + ry2_step;
                    use_dx_next = 1'b1;
                    if (dec_reg[DEC_W-1])
                    begin
                        use_dy_next = 1'b0;
                    end
                    else
                    begin
                        y_next      = y_reg - POSY_W'(1);
                        dy_next     = dy_reg - rx2_step;
                        use_dy_next = 1'b1;
                    end
                end
                else
                begin
                    y_next      = y_reg - POSY_W'(1);
                    dy_next     = dy_reg - rx2_step;
                    use_dy_next = 1'b1;
                    if (!dec_reg[DEC_W-1] && (dec_reg != '0))
                    begin
                        use_dx_next = 1'b0;
                    end
                    else
                    begin
                        x_next      = x_reg + POSX_W'(1);
                        dx_next     = dx_reg + ry2_step;
                        use_dx_next = 1'b1;
                    end
                    // y goes below zero: last step of the ellipse
                    if (y_reg == '0)
                    begin
                        active_next = 1'b0;
                    end
                end
                state_next = ST_TERM;
            end

            ST_TERM:
            begin
                term_next = (use_dx_reg ? dx_d : '0) - (use_dy_reg ? dy_d : '0)
                          + (r2_reg ? rx2_d : ry2_d);
                state_next = ST_ACC;
            end

            // Decision update and region test
            ST_ACC:
            begin
                dec_next = dec_reg + (term_reg <<< 2);
                if (!r2_reg && !(dx_reg < dy_reg))
                begin
                    r2_next    = 1'b1;
                    mop_next   = MOP_TX2;
                    phase_next = 1'b0;
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            // Multiply: issue on phase 0, use the product on phase 1
            ST_MUL:
            begin
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next = 1'b0;
                    case (mop_reg)
                        MOP_RX2:
                        begin
                            rx2_next = mul_p[RSQ_W-1:0];
                            mop_next = MOP_RY2;
                        end
                        MOP_RY2:
                        begin
                            ry2_next = mul_p[RSQ_W-1:0];
                            dec_next = prod_x4 + rx2_d;
                            mop_next = MOP_DY0;
                        end
                        MOP_DY0:
                        begin
                            dy_next  = prod_x2;
                            dec_next = dec_reg - prod_x4;
                            if (!(dx_reg < prod_x2))
                            begin
                                r2_next  = 1'b1;
                                mop_next = MOP_TX2;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                        MOP_TX2:
                        begin
                            t_next   = mul_p[MOP_W-1:0];
                            mop_next = MOP_D_TX;
                        end
                        MOP_D_TX:
                        begin
                            dec_next = prod_d;
                            mop_next = MOP_TY2;
                        end
                        MOP_TY2:
                        begin
                            t_next   = mul_p[MOP_W-1:0];
                            mop_next = MOP_D_TY;
                        end
                        MOP_D_TY:
                        begin
                            dec_next = dec_reg + prod_x4;
                            mop_next = MOP_D_RR;
                        end
                        MOP_D_RR:
                        begin
                            dec_next   = dec_reg - prod_x4;
                            state_next = ST_IDLE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mop_reg    <= MOP_RX2;
            phase_reg  <= 1'b0;
            active_reg <= 1'b0;
            r2_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mop_reg    <= mop_next;
            phase_reg  <= phase_next;
            active_reg <= active_next;
            r2_reg     <= r2_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        use_dx_reg <= use_dx_next;
        use_dy_reg <= use_dy_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        rx2_reg    <= rx2_next;
        ry2_reg    <= ry2_next;
        t_reg      <= t_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        dec_reg    <= dec_next;
        term_reg   <= term_next;
    end

    mer_emit #(
        .COORD_BITS (COORD_BITS)
    ) u_emit (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (emit_cmd),
        .center_x        (cx_reg),
        .center_y        (cy_reg),
        .pos_x           (x_reg),
        .pos_y           (y_reg),
        .busy            (emit_busy),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_x           (out_x),
        .out_y           (out_y),
        .out_point_valid (out_pv),
        .out_last        (m_axis_tlast),
        .out_done        (out_done)
    );

    // Output pack
    assign m_axis_tdata = OUT_DATA_W'({out_y, out_x});
    assign m_axis_tuser = {out_done, out_pv};

`ifndef SYNTHESIS
    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_op == OP_START) |=> (state_reg == ST_MUL && mop_reg == MOP_RX2))
        else $error("start item did not begin the setup multiplies");

    a_region_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && active_reg && !r2_reg) |-> (dx_reg < dy_reg))
        else $error("idle in region one with slope test failed");

    a_region_two: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && active_reg && r2_reg) |-> !(dx_reg < dy_reg))
        else $error("idle in region two with slope test passing");
`endif

endmodule
